[rtl/core/at_command_responder_defines.svh]
// Assertion helpers shared by the responder RTL.
// Each use names the label, the antecedent, the consequent and the message.
`ifndef AT_COMMAND_RESPONDER_DEFINES_SVH
`define AT_COMMAND_RESPONDER_DEFINES_SVH

`define ACR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ACR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/acr_pkg.sv]
`timescale 1ns / 1ps

package acr_pkg;

  localparam int unsigned MESSAGE_DEPTH = 192;
  localparam int unsigned PREFIX_DEPTH  = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned MAX_ITEMS     = 20;
  localparam int unsigned STEP_W        = $clog2(MAX_ITEMS);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_ESC = 8'h1B;
  localparam logic [7:0] CHAR_SUB = 8'h1A;

  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_CMD     = 3'd1,
    PS_LF      = 3'd2,
    PS_FIRST   = 3'd3,
    PS_SECOND  = 3'd4,
    PS_MESSAGE = 3'd5
  } pstate_e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_END   = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  // What the back end has to send after the optional CR LF echo.
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PROMPT = 3'd1,
    ACT_READY  = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_OK     = 3'd4,
    ACT_END    = 3'd5,
    ACT_BYTE   = 3'd6
  } act_e;

  typedef struct packed {
    logic       crlf;
    act_e       act;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  function automatic logic [7:0] ok_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = "O";
      2'd1:    ch = "K";
      2'd2:    ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ready_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "+";
      4'd1:    ch = "C";
      4'd2:    ch = "P";
      4'd3:    ch = "I";
      4'd4:    ch = "N";
      4'd5:    ch = ":";
      4'd6:    ch = " ";
      4'd7:    ch = "R";
      4'd8:    ch = "E";
      4'd9:    ch = "A";
      4'd10:   ch = "D";
      4'd11:   ch = "Y";
      4'd12:   ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
    return ch;
  endfunction

  // Index of the final item of an action's sequence.
  function automatic logic [STEP_W-1:0] act_last(input act_e act);
    logic [STEP_W-1:0] n;
    case (act)
      ACT_PROMPT: n = STEP_W'(1);
      ACT_READY:  n = STEP_W'(17);
      ACT_RESET:  n = STEP_W'(4);
      ACT_OK:     n = STEP_W'(3);
      ACT_END:    n = STEP_W'(4);
      default:    n = '0;
    endcase
    return n;
  endfunction

  function automatic item_t act_item(input act_e act, input logic [STEP_W-1:0] j,
                                     input logic [7:0] byte_val);
    item_t it;
    logic [STEP_W-1:0] k;
    it.kind = KIND_CHAR;
    it.data = '0;
    k = j - STEP_W'(1);
    case (act)
      ACT_PROMPT: it.data = (j == '0) ? ">" : " ";
      ACT_READY: begin
        if (j < STEP_W'(14)) begin
          it.data = ready_char(j[3:0]);
        end else begin
          it.data = ok_char(2'(j - STEP_W'(14)));
        end
      end
      ACT_RESET: begin
        if (j == '0) begin
          it.kind = KIND_RESET;
        end else begin
          it.data = ok_char(k[1:0]);
        end
      end
      ACT_OK: it.data = ok_char(j[1:0]);
      ACT_END: begin
        if (j == '0) begin
          it.kind = KIND_END;
        end else begin
          it.data = ok_char(k[1:0]);
        end
      end
      ACT_BYTE: begin
        it.kind = KIND_BYTE;
        it.data = byte_val;
      end
      default: it.data = '0;
    endcase
    return it;
  endfunction

endpackage

[rtl/core/at_command_responder.sv]
`timescale 1ns / 1ps
// Each item's job passes through the job queue, and its results through a registered output.
// Throughput: one input item per cycle while each yields at most one result; an item
// with n results holds the result sequencer until the last is taken, and a two-entry
// job queue decouples it. The input stalls only when that queue is full.
// Reset: asynchronous, active low; parser idle, counters cleared, queue and output empty.
module at_command_responder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic          accept;
  logic          push, full, pop, job_valid;
  acr_pkg::job_t job_in, job_out;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  acr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .job_o     (job_in)
  );

  acr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  acr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

[rtl/core/acr_front.sv]
`timescale 1ns / 1ps
`include "at_command_responder_defines.svh"

module acr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          push_o,
  output acr_pkg::job_t job_o
);

  acr_pkg::pstate_e state_q, state_d, st;
  logic [7:0] prefix_q [acr_pkg::PREFIX_DEPTH];
  logic [2:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] hex_q, hex_d;
  logic       half_q, half_d;
  logic       pre_we;
  logic [3:0] nib;
  logic       is_cr;
  logic       m_cmgs, m_cpin, m_z9;

  assign is_cr = (rx_byte_i == acr_pkg::CHAR_CR);

  assign m_cmgs = (len_q == 3'(acr_pkg::PREFIX_DEPTH)) &&
                  prefix_q[0] == "+" && prefix_q[1] == "C" && prefix_q[2] == "M" &&
                  prefix_q[3] == "G" && prefix_q[4] == "S" && prefix_q[5] == "=";
  assign m_cpin = (len_q == 3'(acr_pkg::PREFIX_DEPTH)) &&
                  prefix_q[0] == "+" && prefix_q[1] == "C" && prefix_q[2] == "P" &&
                  prefix_q[3] == "I" && prefix_q[4] == "N" && prefix_q[5] == "?";
  assign m_z9   = (len_q >= 3'd2) && prefix_q[0] == "Z" && prefix_q[1] == "9";

  // Lowercase letters and every other non-hex character give a zero nibble.
  always_comb begin
    if (rx_byte_i >= "A" && rx_byte_i <= "F") begin
      nib = 4'(rx_byte_i - 8'h37);
    end else if (rx_byte_i >= "0" && rx_byte_i <= "9") begin
      nib = rx_byte_i[3:0];
    end else begin
      nib = 4'd0;
    end
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    count_d  = count_q;
    hex_d    = hex_q;
    half_d   = half_q;
    pre_we   = 1'b0;
    job_o    = '{crlf: 1'b0, act: acr_pkg::ACT_NONE, data: 8'd0};
    st       = (rx_byte_i == acr_pkg::CHAR_ESC) ? acr_pkg::PS_IDLE : state_q;
    if (accept_i) begin
      job_o.crlf = is_cr;
      case (st)
        acr_pkg::PS_LF: begin
          state_d = (rx_byte_i == acr_pkg::CHAR_LF) ? acr_pkg::PS_FIRST : acr_pkg::PS_IDLE;
        end
        acr_pkg::PS_FIRST: begin
          state_d = (rx_byte_i == "A") ? acr_pkg::PS_SECOND : acr_pkg::PS_IDLE;
        end
        acr_pkg::PS_SECOND: begin
          if (rx_byte_i == "T") begin
            state_d = acr_pkg::PS_CMD;
            len_d   = 3'd0;
          end else begin
            state_d = acr_pkg::PS_IDLE;
          end
        end
        acr_pkg::PS_CMD: begin
          if (is_cr) begin
            state_d = acr_pkg::PS_LF;
            if (m_cmgs) begin
              job_o.act = acr_pkg::ACT_PROMPT;
              state_d   = acr_pkg::PS_MESSAGE;
              count_d   = 8'd0;
              half_d    = 1'b0;
            end else if (m_cpin) begin
              job_o.act = acr_pkg::ACT_READY;
            end else if (m_z9) begin
              job_o.act = acr_pkg::ACT_RESET;
            end else begin
              job_o.act = acr_pkg::ACT_OK;
            end
          end else if (len_q < 3'(acr_pkg::PREFIX_DEPTH)) begin
            pre_we = 1'b1;
            len_d  = len_q + 3'd1;
          end
        end
        acr_pkg::PS_MESSAGE: begin
          if (rx_byte_i == acr_pkg::CHAR_SUB) begin
            job_o.act = acr_pkg::ACT_END;
            state_d   = acr_pkg::PS_IDLE;
          end else begin
            hex_d  = {hex_q[3:0], nib};
            half_d = ~half_q;
            // Once the message is full, bytes are dropped but pairing goes on.
            if (half_q && count_q < 8'(acr_pkg::MESSAGE_DEPTH)) begin
              job_o.act  = acr_pkg::ACT_BYTE;
              job_o.data = hex_d;
              count_d    = count_q + 8'd1;
            end
          end
        end
        default: begin
          state_d = is_cr ? acr_pkg::PS_LF : acr_pkg::PS_IDLE;
        end
      endcase
    end
  end

  assign push_o = accept_i && (job_o.crlf || job_o.act != acr_pkg::ACT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acr_pkg::PS_IDLE;
      len_q   <= 3'd0;
      count_q <= 8'd0;
      hex_q   <= 8'd0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      count_q <= count_d;
      hex_q   <= hex_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < acr_pkg::PREFIX_DEPTH; i++) begin
      if (pre_we && len_q == 3'(i)) begin
        prefix_q[i] <= rx_byte_i;
      end
    end
  end

  `ACR_ASSERT_NEXT(a_open_cmd, accept_i && state_q == acr_pkg::PS_SECOND && rx_byte_i == "T", state_q == acr_pkg::PS_CMD && len_q == 3'd0, "AT did not open a command")
  `ACR_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= 8'(acr_pkg::MESSAGE_DEPTH), "message count over depth")

endmodule

[rtl/core/acr_queue.sv]
`timescale 1ns / 1ps
`include "at_command_responder_defines.svh"

module acr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output acr_pkg::job_t data_o
);

  acr_pkg::job_t mem_q [acr_pkg::QUEUE_DEPTH];
  logic [acr_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [acr_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (acr_pkg::QPTR_W + 1)'(acr_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + acr_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + acr_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (acr_pkg::QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (acr_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ACR_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "push into a full queue")
  `ACR_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "pop from an empty queue")

endmodule

[rtl/core/acr_back.sv]
`timescale 1ns / 1ps
`include "at_command_responder_defines.svh"

module acr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  acr_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    data_o,
  output logic          last_o
);

  logic [acr_pkg::STEP_W-1:0] step_q, step_d, j;
  logic          out_valid_q;
  acr_pkg::item_t item_q, item;
  logic          last_q, item_last;
  logic          load;

  // Step through the CR LF echo first, then the action's own sequence.
  always_comb begin
    j = step_q - (job_i.crlf ? acr_pkg::STEP_W'(2) : acr_pkg::STEP_W'(0));
    if (job_i.crlf && step_q < acr_pkg::STEP_W'(2)) begin
      item.kind = acr_pkg::KIND_CHAR;
      item.data = (step_q == '0) ? acr_pkg::CHAR_CR : acr_pkg::CHAR_LF;
      item_last = (job_i.act == acr_pkg::ACT_NONE) && (step_q == acr_pkg::STEP_W'(1));
    end else begin
      item      = acr_pkg::act_item(job_i.act, j, job_i.data);
      item_last = (j == acr_pkg::act_last(job_i.act));
    end
  end

  assign load   = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o  = load && item_last;
  assign step_d = pop_o ? '0 : (load ? step_q + acr_pkg::STEP_W'(1) : step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item;
      last_q <= item_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = item_q.kind;
  assign data_o      = item_q.data;
  assign last_o      = last_q;

  `ACR_ASSERT_IMPL(a_step_bound, 1'b1, step_q < acr_pkg::STEP_W'(acr_pkg::MAX_ITEMS), "step beyond the longest answer")
  `ACR_ASSERT_NEXT(a_pop_shows_last, pop_o, out_valid_o && last_o, "job retired without its final item")

endmodule

[dv/at_command_responder_tb.sv]
`timescale 1ns / 1ps

module at_command_responder_tb;

  typedef struct packed {
    acr_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } reply_t;

  // One stimulus row; typed rows carry their replies, all others use the predictor.
  typedef struct packed {
    logic [7:0]       rx;
    logic             typed;
    logic [2:0]       n;
    reply_t [4:0]     res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       last_o;

  at_command_responder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  always #4 clk_i = ~clk_i;

  stim_row_t stim_rows[$];
  int        cur_row = 0;
  int        n_directed = 0;
  string     hex_digits = "0123456789ABCDEF";
  string     cmd_chars = "+CMGSPINZ9?=:AT";

  // Parser state as the predictor sees it.
  acr_pkg::pstate_e p_state = acr_pkg::PS_IDLE;
  logic [7:0] p_prefix [acr_pkg::PREFIX_DEPTH] = '{default: 8'h00};
  logic [2:0] p_len = 3'd0;
  logic [7:0] p_count = 8'd0;
  logic [7:0] p_shift = 8'd0;
  logic       p_half = 1'b0;

  reply_t step_out[$];
  reply_t pending_replies[$];

  int items_accepted = 0;
  int replies_checked = 0;
  int kind_seen [4] = '{default: 0};
  int mismatch_count = 0;
  int stray_count = 0;
  int report_count = 0;
  int cyc = 0;

  function automatic reply_t rep(input acr_pkg::kind_e k, input logic [7:0] d);
    reply_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] rx);
    stim_row_t row;
    row = '0;
    row.rx = rx;
    stim_rows.push_back(row);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_typed(input logic [7:0] rx, input int n, input reply_t r0, input reply_t r1,
                           input reply_t r2, input reply_t r3, input reply_t r4);
    stim_row_t row;
    row = '0;
    row.rx = rx;
    row.typed = 1'b1;
    row.n = 3'(n);
    row.res[0] = r0;
    row.res[1] = r1;
    row.res[2] = r2;
    row.res[3] = r3;
    row.res[4] = r4;
    if (n > 0) row.res[n-1].last = 1'b1;
    stim_rows.push_back(row);
  endtask

  function automatic logic [7:0] hex_char();
    return hex_digits[$urandom_range(0, 15)];
  endfunction

  function automatic logic [7:0] cmd_char();
    logic [7:0] ch;
    if ($urandom_range(0, 9) < 7) begin
      ch = cmd_chars[$urandom_range(0, cmd_chars.len() - 1)];
    end else begin
      ch = 8'($urandom_range(0, 255));
      if (ch == acr_pkg::CHAR_CR) ch = "x";
    end
    return ch;
  endfunction

  task automatic add_message(input int nchar);
    logic [7:0] ch;
    int         r;
    for (int k = 0; k < nchar; k++) begin
      if ($urandom_range(0, 4) != 0) begin
        ch = hex_char();
      end else begin
        ch = 8'($urandom_range(0, 255));
        if (ch == acr_pkg::CHAR_SUB || ch == acr_pkg::CHAR_ESC) ch = "a";
      end
      add_byte(ch);
    end
    r = $urandom_range(0, 19);
    if (r < 17) add_byte(acr_pkg::CHAR_SUB);
    else if (r < 19) add_byte(acr_pkg::CHAR_ESC);
  endtask

  task automatic add_random_phrase();
    int    pick;
    int    body_sel;
    int    len;
    string body;
    string pat;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // Mostly a clean opening from any state; sometimes the short form that
      // only works right after a previous command.
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        add_byte(acr_pkg::CHAR_ESC);
        add_byte(acr_pkg::CHAR_CR);
      end else if (pick < 8) begin
        add_byte(acr_pkg::CHAR_CR);
      end
      add_byte(acr_pkg::CHAR_LF);
      add_text("AT");
      body_sel = $urandom_range(0, 9);
      case (body_sel)
        0, 1, 2: body = "+CMGS=";
        3:       body = "+CPIN?";
        4:       body = "Z9";
        5: begin
          case ($urandom_range(0, 2))
            0:       pat = "+CMGS=";
            1:       pat = "+CPIN?";
            default: pat = "Z9";
          endcase
          len = $urandom_range(0, pat.len() - 1);
          body = (len == 0) ? "" : pat.substr(0, len - 1);
        end
        default: begin
          body = "";
          len = $urandom_range(0, 9);
          for (int k = 0; k < len; k++) body = {body, string'(cmd_char())};
        end
      endcase
      add_text(body);
      if (body_sel <= 4 && $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) add_byte(cmd_char());
      end
      add_byte(acr_pkg::CHAR_CR);
      if (body_sel <= 2) add_message($urandom_range(0, 24));
    end else if (pick < 85) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // An opening that breaks off at a random point.
      add_byte(acr_pkg::CHAR_ESC);
      add_byte(acr_pkg::CHAR_CR);
      add_byte(($urandom_range(0, 1) != 0) ? acr_pkg::CHAR_LF : cmd_char());
      add_byte(($urandom_range(0, 1) != 0) ? 8'("A") : cmd_char());
      add_byte(cmd_char());
    end
  endtask

  task automatic emit(input acr_pkg::kind_e k, input logic [7:0] d);
    step_out.push_back(rep(k, d));
  endtask

  task automatic emit_line(input string s);
    for (int i = 0; i < s.len(); i++) emit(acr_pkg::KIND_CHAR, s[i]);
    emit(acr_pkg::KIND_CHAR, acr_pkg::CHAR_CR);
    emit(acr_pkg::KIND_CHAR, acr_pkg::CHAR_LF);
  endtask

  function automatic bit prefix_is(input string pat);
    bit hit;
    hit = (p_len >= pat.len());
    for (int i = 0; i < pat.len() && hit; i++) begin
      if (p_prefix[i] != pat[i]) hit = 1'b0;
    end
    return hit;
  endfunction

  // Computes the replies to one received byte and advances the parser copy.
  task automatic predict_replies(input logic [7:0] c);
    logic [3:0] nib;
    reply_t     r;
    step_out.delete();
    if (c == acr_pkg::CHAR_CR) begin
      emit(acr_pkg::KIND_CHAR, acr_pkg::CHAR_CR);
      emit(acr_pkg::KIND_CHAR, acr_pkg::CHAR_LF);
    end else if (c == acr_pkg::CHAR_ESC) begin
      p_state = acr_pkg::PS_IDLE;
    end
    case (p_state)
      acr_pkg::PS_LF: begin
        p_state = (c == acr_pkg::CHAR_LF) ? acr_pkg::PS_FIRST : acr_pkg::PS_IDLE;
      end
      acr_pkg::PS_FIRST: begin
        p_state = (c == "A") ? acr_pkg::PS_SECOND : acr_pkg::PS_IDLE;
      end
      acr_pkg::PS_SECOND: begin
        if (c == "T") begin
          p_state = acr_pkg::PS_CMD;
          p_len = 3'd0;
        end else begin
          p_state = acr_pkg::PS_IDLE;
        end
      end
      acr_pkg::PS_CMD: begin
        if (c == acr_pkg::CHAR_CR) begin
          if (prefix_is("+CMGS=")) begin
            emit(acr_pkg::KIND_CHAR, ">");
            emit(acr_pkg::KIND_CHAR, " ");
            p_state = acr_pkg::PS_MESSAGE;
            p_count = 8'd0;
            p_half = 1'b0;
          end else begin
            if (prefix_is("+CPIN?")) emit_line("+CPIN: READY");
            else if (prefix_is("Z9")) emit(acr_pkg::KIND_RESET, 8'h00);
            emit_line("OK");
            p_state = acr_pkg::PS_LF;
          end
        end else if (p_len < acr_pkg::PREFIX_DEPTH) begin
          p_prefix[p_len] = c;
          p_len = p_len + 3'd1;
        end
      end
      acr_pkg::PS_MESSAGE: begin
        if (c == acr_pkg::CHAR_SUB) begin
          emit(acr_pkg::KIND_END, 8'h00);
          emit_line("OK");
          p_state = acr_pkg::PS_IDLE;
        end else begin
          // Anything outside 0-9 and A-F, lowercase included, shifts in a zero nibble.
          if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
          else if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else nib = 4'h0;
          p_shift = {p_shift[3:0], nib};
          if (p_half && p_count < acr_pkg::MESSAGE_DEPTH) begin
            emit(acr_pkg::KIND_BYTE, p_shift);
            p_count = p_count + 8'd1;
          end
          p_half = ~p_half;
        end
      end
      default: p_state = (c == acr_pkg::CHAR_CR) ? acr_pkg::PS_LF : acr_pkg::PS_IDLE;
    endcase
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endtask

  // Receiver: the stall pattern steps through four modes chosen by bits 8:7 of the cycle count.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case (cyc[8:7])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready_i <= cyc[2];
      default: out_ready_i <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk_i) begin : scoreboard
    stim_row_t row;
    reply_t    want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_replies(rx_byte_i);
        row = stim_rows[cur_row];
        if (row.typed) begin
          for (int k = 0; k < row.n; k++) pending_replies.push_back(row.res[k]);
        end else begin
          foreach (step_out[k]) pending_replies.push_back(step_out[k]);
        end
        items_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        replies_checked++;
        kind_seen[kind_o]++;
        if (pending_replies.size() == 0) begin
          stray_count++;
          if (report_count < 10) begin
            report_count++;
            $display("%0t: unexpected reply kind %0d data %02h last %0d",
                     $time, kind_o, data_o, last_o);
          end
        end else begin
          want = pending_replies.pop_front();
          if (kind_o !== want.kind || data_o !== want.data || last_o !== want.last) begin
            mismatch_count++;
            if (report_count < 10) begin
              report_count++;
              $display("%0t: reply kind %0d data %02h last %0d, expected kind %0d data %02h last %0d",
                       $time, kind_o, data_o, last_o, want.kind, want.data, want.last);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    int     gap;
    int     burst_left;
    int     rand_start;
    reply_t nil;
    nil = '0;

    // Directed rows: Z9, a long +CMGS= command with a short message, then +CPIN?.
    add_typed(acr_pkg::CHAR_CR, 2, rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_CR),
              rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_LF), nil, nil, nil);
    add_byte(acr_pkg::CHAR_LF);
    add_text("ATZ9");
    add_byte(acr_pkg::CHAR_CR);
    add_byte(acr_pkg::CHAR_LF);
    add_text("AT+CMGS=");
    // A seventh character is beyond the kept prefix and changes nothing.
    add_typed(8'hFF, 0, nil, nil, nil, nil, nil);
    add_byte(acr_pkg::CHAR_CR);
    add_byte("F");
    add_byte(8'h00);
    add_typed(acr_pkg::CHAR_SUB, 5, rep(acr_pkg::KIND_END, 8'h00),
              rep(acr_pkg::KIND_CHAR, "O"), rep(acr_pkg::KIND_CHAR, "K"),
              rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_CR),
              rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_LF));
    add_typed(acr_pkg::CHAR_ESC, 0, nil, nil, nil, nil, nil);
    add_typed(acr_pkg::CHAR_CR, 2, rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_CR),
              rep(acr_pkg::KIND_CHAR, acr_pkg::CHAR_LF), nil, nil, nil);
    add_byte(acr_pkg::CHAR_LF);
    add_text("AT+CPIN?");
    add_byte(acr_pkg::CHAR_CR);
    n_directed = stim_rows.size();

    // One message that runs past the depth limit, then random phrases.
    add_byte(acr_pkg::CHAR_ESC);
    add_byte(acr_pkg::CHAR_CR);
    add_byte(acr_pkg::CHAR_LF);
    add_text("AT+CMGS=");
    add_byte(acr_pkg::CHAR_CR);
    for (int k = 0; k < 2 * acr_pkg::MESSAGE_DEPTH + 16; k++) add_byte(hex_char());
    add_byte(acr_pkg::CHAR_SUB);
    rand_start = stim_rows.size();
    while (stim_rows.size() - rand_start < 200) add_random_phrase();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = 0;
    for (int i = 0; i < stim_rows.size(); i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : $urandom_range(0, 2);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      in_valid_i <= 1'b1;
      rx_byte_i <= stim_rows[i].rx;
      cur_row <= i;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      burst_left--;
    end
    in_valid_i <= 1'b0;

    // Let the last item reach the predictor, drain, then watch for stray replies.
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes (%0d directed); checked %0d replies: %0d characters,",
             items_accepted, n_directed, replies_checked, kind_seen[acr_pkg::KIND_CHAR]);
    $display("%0d message bytes, %0d message ends, %0d reset requests; %0d mismatches, %0d stray.",
             kind_seen[acr_pkg::KIND_BYTE], kind_seen[acr_pkg::KIND_END],
             kind_seen[acr_pkg::KIND_RESET], mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/acr_pkg.sv
rtl/core/acr_front.sv
rtl/core/acr_queue.sv
rtl/core/acr_back.sv
rtl/core/at_command_responder.sv
dv/at_command_responder_tb.sv
